[rtl/core/rkc_pkg.sv]
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared constants and controller/datapath types of the replay key cache.
// ----------------------------------------------------------------------------
package rkc_pkg;

  localparam int unsigned CAPACITY_DFLT  = 64;
  localparam int unsigned KEY_BYTES_DFLT = 32;
  localparam int unsigned WORD_W         = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_FINISH
  } rkc_state_e;

  // controller to datapath
  typedef struct packed {
    logic start;   // capture key and action, clear hit, rewind index
    logic rd;      // read entry at search index, advance index
    logic commit;  // write key if needed, load result register
  } rkc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // no filled entries
    logic last;      // search index points at last filled entry
    logic out_free;  // result register can take a beat
  } rkc_sts_t;

endpackage

[rtl/core/replay_key_cache.sv]
// ----------------------------------------------------------------------------
// replay_key_cache
// Replay-protection key table with linear search and FIFO replacement.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i, in_stall_o, action_i,         | in
//          | key_word0_i .. key_word3_i                |
//  out     | out_valid_o, out_stall_i, hit_o, stored_o | out
//
//  the single memory read port scans one entry per cycle; an empty table
//  skips the search. the next beat is taken once the result is loaded.
//  reset clears the fill count and eviction pointer; the key store is
//  not cleared. a stalled result holds one beat while the next item runs.
// ----------------------------------------------------------------------------
module replay_key_cache import rkc_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DFLT,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DFLT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [WORD_W-1:0] key_word0_i,
  input  logic [WORD_W-1:0] key_word1_i,
  input  logic [WORD_W-1:0] key_word2_i,
  input  logic [WORD_W-1:0] key_word3_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o,
  output logic              stored_o
);

  rkc_cmd_t cmd;
  rkc_sts_t sts;

  rkc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rkc_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (action_i),
    .key_word0_i (key_word0_i),
    .key_word1_i (key_word1_i),
    .key_word2_i (key_word2_i),
    .key_word3_i (key_word3_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .stored_o    (stored_o)
  );

endmodule

[rtl/core/rkc_ctrl.sv]
// ----------------------------------------------------------------------------
// rkc_ctrl
// Sequencer for one item: accept, linear search, drain, commit.
// ----------------------------------------------------------------------------
module rkc_ctrl import rkc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rkc_sts_t sts_i,
  output rkc_cmd_t cmd_o
);

  rkc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.empty ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.rd = 1'b1;
        if (sts_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read data is compared in this cycle
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/rkc_dpath.sv]
// ----------------------------------------------------------------------------
// rkc_dpath
// Key store memory, fill and eviction counters, compare and result register.
// ----------------------------------------------------------------------------
module rkc_dpath import rkc_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DFLT,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DFLT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              action_i,
  input  logic [WORD_W-1:0] key_word0_i,
  input  logic [WORD_W-1:0] key_word1_i,
  input  logic [WORD_W-1:0] key_word2_i,
  input  logic [WORD_W-1:0] key_word3_i,
  input  rkc_cmd_t          cmd_i,
  output rkc_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o,
  output logic              stored_o
);

  localparam int unsigned KeyW = KEY_BYTES * 8;
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [KeyW-1:0] mem [CAPACITY];

  logic [4*WORD_W-1:0] key_full;
  logic [KeyW-1:0]     key_q;
  logic [KeyW-1:0]     rd_data_q;
  logic                rd_valid_q;
  logic                action_q;
  logic                hit_q;
  logic [IdxW-1:0]     idx_q;
  logic [CntW-1:0]     fill_q;
  logic [IdxW-1:0]     evict_q;
  logic                full;
  logic                do_write;
  logic [IdxW-1:0]     wr_addr;

  assign key_full = {key_word3_i, key_word2_i, key_word1_i, key_word0_i};
  assign full     = (fill_q == CntW'(CAPACITY));
  assign do_write = cmd_i.commit && action_q && !hit_q;
  assign wr_addr  = full ? evict_q : fill_q[IdxW-1:0];

  assign sts_o.empty    = (fill_q == '0);
  assign sts_o.last     = ((CntW'(idx_q) + CntW'(1)) == fill_q);
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

  // payload capture, bytes past the key length are dropped
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q    <= key_full[KeyW-1:0];
      action_q <= action_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[wr_addr] <= key_q;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      hit_q      <= 1'b0;
      idx_q      <= '0;
    end else begin
      rd_valid_q <= cmd_i.rd;
      if (cmd_i.start) begin
        hit_q <= 1'b0;
        idx_q <= '0;
      end else begin
        if (rd_valid_q && (rd_data_q == key_q)) begin
          hit_q <= 1'b1;
        end
        if (cmd_i.rd) begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

  // append until full, then overwrite oldest slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      evict_q <= '0;
    end else if (do_write) begin
      if (!full) begin
        fill_q <= fill_q + CntW'(1);
      end else if (evict_q == IdxW'(CAPACITY - 1)) begin
        evict_q <= '0;
      end else begin
        evict_q <= evict_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o    <= hit_q;
      stored_o <= action_q && !hit_q;
    end
  end

endmodule

[rtl/core/rkc_checker.sv]
// ----------------------------------------------------------------------------
// rkc_checker
// Port-level checks of the replay key cache, bound to the top level.
// ----------------------------------------------------------------------------
module rkc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic hit_o,
  input logic stored_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable({hit_o, stored_o}))
    else $error("result beat changed under stall");

  // a key already present is never written again
  a_hit_not_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && stored_o))
    else $error("hit and stored both set");

  // one item in flight: busy right after an accept
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // no result comes out the cycle after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_acc))
    else $error("result appeared one cycle after accept");

endmodule

bind replay_key_cache rkc_checker u_rkc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o),
  .stored_o    (stored_o)
);

[verif/replay_key_cache_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// replay_key_cache_checker
// Watches both channels of the replay key cache, keeps its own copy of the
// key table with first-in first-out replacement, and compares every result
// beat against the hit and stored flags worked out for the oldest open item.
// ----------------------------------------------------------------------------
module replay_key_cache_checker import rkc_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DFLT,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DFLT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              action_i,
  input  logic [WORD_W-1:0] key_word0_i,
  input  logic [WORD_W-1:0] key_word1_i,
  input  logic [WORD_W-1:0] key_word2_i,
  input  logic [WORD_W-1:0] key_word3_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              hit_i,
  input  logic              stored_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       pending_o
);

  typedef logic [4*WORD_W-1:0] key_t;

  typedef struct packed {
    logic hit;
    logic stored;
  } key_verdict_t;

  key_t         key_tab [CAPACITY];
  int unsigned  fill_cnt;
  int unsigned  evict_ptr;
  key_verdict_t verdict_q [$];

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  // bytes past KEY_BYTES never reach the table
  function automatic key_t key_mask();
    key_t m;
    m = '0;
    for (int b = 0; b < 4 * WORD_W / 8; b++) begin
      if (b < KEY_BYTES) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

  // only filled slots take part in the search
  function automatic key_verdict_t search_and_insert(logic act, key_t key);
    key_verdict_t v;
    int unsigned  slot;
    v.hit    = 1'b0;
    v.stored = 1'b0;
    for (int unsigned i = 0; i < fill_cnt; i++) begin
      if (key_tab[i] == key) v.hit = 1'b1;
    end
    if (act && !v.hit) begin
      if (fill_cnt < CAPACITY) begin
        slot     = fill_cnt;
        fill_cnt = fill_cnt + 1;
      end else begin
        slot      = evict_ptr;
        evict_ptr = (evict_ptr + 1) % CAPACITY;
      end
      key_tab[slot] = key;
      v.stored      = 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_verdict_t want;
    key_verdict_t got;
    if (!rst_ni) begin
      fill_cnt  = 0;
      evict_ptr = 0;
      verdict_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        verdict_q.push_back(search_and_insert(action_i,
          {key_word3_i, key_word2_i, key_word1_i, key_word0_i} & key_mask()));
      end
      if (out_valid_i && !out_stall_i) begin
        got.hit    = hit_i;
        got.stored = stored_i;
        if (verdict_q.size() == 0) begin
          mismatch_cnt_o = mismatch_cnt_o + 1;
          if (mismatch_cnt_o <= 10) begin
            $display("%0t: result beat with no open item: hit=%b stored=%b",
                     $realtime, got.hit, got.stored);
          end
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            mismatch_cnt_o = mismatch_cnt_o + 1;
            if (mismatch_cnt_o <= 10) begin
              $display("%0t: result mismatch: expected hit=%b stored=%b, got hit=%b stored=%b",
                       $realtime, want.hit, want.stored, got.hit, got.stored);
            end
          end
        end
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

[verif/replay_key_cache_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// replay_key_cache_test
// Drives lookups and inserts into the replay key cache: a directed opening on
// empty, duplicate and near-miss keys, then random beats drawn mostly from a
// key pool larger than the table so that hits and evictions are common. Four
// idling phases on sender and receiver; the checker reports mismatches.
// ----------------------------------------------------------------------------
module replay_key_cache_test;
  import rkc_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DFLT;
  localparam int unsigned KEY_BYTES    = KEY_BYTES_DFLT;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned POOL_SIZE    = CAPACITY + CAPACITY / 2;
  localparam int unsigned QUIET_LIMIT  = 4000;

  typedef logic [4*WORD_W-1:0] key_t;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_INSERT = 1'b1
  } key_action_e;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              action    = 1'b0;
  logic [WORD_W-1:0] key_word0 = '0;
  logic [WORD_W-1:0] key_word1 = '0;
  logic [WORD_W-1:0] key_word2 = '0;
  logic [WORD_W-1:0] key_word3 = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              hit;
  logic              stored;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned quiet_cycles  = 0;
  int unsigned idle_by_phase [4] = '{0, 69, 0, 35};
  int unsigned stall_by_phase[4] = '{0, 0, 69, 35};
  key_t        key_pool [POOL_SIZE];

  replay_key_cache #(
    .CAPACITY (CAPACITY),
    .KEY_BYTES(KEY_BYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .action_i   (action),
    .key_word0_i(key_word0),
    .key_word1_i(key_word1),
    .key_word2_i(key_word2),
    .key_word3_i(key_word3),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .hit_o      (hit),
    .stored_o   (stored)
  );

  replay_key_cache_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BYTES(KEY_BYTES)
  ) i_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .action_i      (action),
    .key_word0_i   (key_word0),
    .key_word1_i   (key_word1),
    .key_word2_i   (key_word2),
    .key_word3_i   (key_word3),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .hit_i         (hit),
    .stored_i      (stored),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ends the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic key_t random_key();
    key_t k;
    for (int w = 0; w < 4 * WORD_W / 32; w++) k[w*32 +: 32] = $urandom();
    return k;
  endfunction

  // returns at the edge where the beat is taken; valid stays high after it
  task automatic send_item(key_action_e act, key_t key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    action    <= act;
    key_word0 <= key[0*WORD_W +: WORD_W];
    key_word1 <= key[1*WORD_W +: WORD_W];
    key_word2 <= key[2*WORD_W +: WORD_W];
    key_word3 <= key[3*WORD_W +: WORD_W];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // hold the sender until every open item has its result
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    key_t probe;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, duplicate insert, all-ones and near misses
    send_item(ACT_LOOKUP, '0);
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, '0);
    send_item(ACT_LOOKUP, '0);
    send_item(ACT_LOOKUP, '1);
    send_item(ACT_INSERT, '1);
    send_item(ACT_LOOKUP, '1);
    probe = '1;
    probe[4*WORD_W-1] = 1'b0;
    send_item(ACT_LOOKUP, probe);
    probe = '1;
    probe[0] = 1'b0;
    send_item(ACT_INSERT, probe);
    send_item(ACT_INSERT, {(2 * WORD_W){2'b01}});
    send_item(ACT_INSERT, {(2 * WORD_W){2'b10}});
    send_item(ACT_LOOKUP, {(2 * WORD_W){2'b01}});
    send_item(ACT_LOOKUP, {(2 * WORD_W){2'b10}});
    for (int w = 0; w < 4; w++) begin
      probe = '0;
      probe[w*WORD_W +: WORD_W] = '1;
      send_item(ACT_INSERT, probe);
    end
    probe = '0;
    probe[2*WORD_W +: WORD_W] = '1;
    send_item(ACT_LOOKUP, probe);
    send_item(ACT_LOOKUP, random_key());
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      stall_pct     = stall_by_phase[phase];
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        key_t        key;
        int unsigned pick;
        if ($urandom_range(49) == 0) drain();
        pick = $urandom_range(99);
        if (pick < 65) begin
          key = key_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (pick < 80) begin
          // one bit off a pooled key must miss
          key = key_pool[$urandom_range(POOL_SIZE - 1)];
          key[$urandom_range(4 * WORD_W - 1)] ^= 1'b1;
        end else begin
          key = random_key();
        end
        send_item(($urandom_range(99) < 55) ? ACT_INSERT : ACT_LOOKUP, key);
      end
      drain();
    end

    repeat (CAPACITY + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[replay_key_cache.f]
rtl/core/rkc_pkg.sv
rtl/core/rkc_ctrl.sv
rtl/core/rkc_dpath.sv
rtl/core/replay_key_cache.sv
rtl/core/rkc_checker.sv
verif/replay_key_cache_checker.sv
verif/replay_key_cache_test.sv
